// ===== rtl/core/icmb_pkg.sv =====
// ----------------------------------------------------------------------------
// icmb_pkg
// Shared widths and constants for the int8 convolution MAC with bias and
// leaky activation.
// ----------------------------------------------------------------------------
package icmb_pkg;

	// field widths
	localparam int ACT_W  = 8;
	localparam int WGT_W  = 8;
	localparam int BIAS_W = 16;
	localparam int PROD_W = ACT_W + WGT_W;
	localparam int ACC_W  = 32;
	localparam int OUT_W  = 16;

	// symmetric clamp bound applied to the accumulator, 256*256/2 - 1
	localparam int CLAMP_LIMIT = 256 * 256 / 2 - 1;

	// divide by ten as multiply by ceil(2^19 / 10) and shift, exact for
	// magnitudes up to 2^18
	localparam int LEAKY_DIVISOR   = 10;
	localparam int DIV_SHIFT       = 19;
	localparam int DIV_MULT        = ((1 << DIV_SHIFT) + LEAKY_DIVISOR - 1) / LEAKY_DIVISOR;
	localparam int DIV_PROD_W      = 2 * OUT_W;

	// reset value of the leaky enable register
	localparam logic LEAKY_RESET = 1'b1;

endpackage

// ===== rtl/core/icmb_leaky.sv =====
// ----------------------------------------------------------------------------
// icmb_leaky
// Leaky activation: a non-positive value is divided by ten, truncating
// toward zero, when enabled. Positive values pass unchanged.
// ----------------------------------------------------------------------------
module icmb_leaky (
	input  logic                               leaky_enable,
	input  logic signed [icmb_pkg::OUT_W-1:0] value,
	output logic signed [icmb_pkg::OUT_W-1:0] result
);
	import icmb_pkg::*;

	logic [OUT_W:0]        mag_wide;
	logic [OUT_W-1:0]      mag;
	logic [DIV_PROD_W-1:0] div_prod;
	logic [OUT_W-1:0]      quot;
	logic [OUT_W-1:0]      neg_quot;
	logic                  non_pos;

	// magnitude of a non-positive value, fits in OUT_W bits unsigned
	assign mag_wide = (OUT_W + 1)'(0) - {value[OUT_W-1], value};
	assign mag      = mag_wide[OUT_W-1:0];

	// reciprocal multiply gives floor(mag / 10)
	assign div_prod = DIV_PROD_W'(mag) * DIV_PROD_W'(DIV_MULT);
	assign quot     = OUT_W'(div_prod >> DIV_SHIFT);
	assign neg_quot = OUT_W'(0) - quot;

	// select divided value only for non-positive input
	assign non_pos = value[OUT_W-1] || (value == '0);
	assign result  = (leaky_enable && non_pos) ? $signed(neg_quot) : value;

endmodule

// ===== rtl/core/int8_conv_mac_bias_leaky.sv =====
// ----------------------------------------------------------------------------
// int8_conv_mac_bias_leaky
// Streaming int8 multiply-accumulate; on the last term the sum is clamped to
// +/-32767, biased with 16-bit wrap and optionally leaky-activated.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  input   | in_valid / in_ready | activation, weight, bias, last_term
//  output  | out_valid/out_ready | out_value
//  config  | cfg_valid/cfg_ready | cfg_data (leaky enable)
//
// One term per cycle while no result waits on out_ready; after its last term
// is taken into the input register, a result passes the product, accumulate and
// clamp, bias add and leaky stages into the output register.
// The whole pipeline advances together and holds while a result waits on
// out_ready, so in_ready is low only during such a stall.
// Reset clears the accumulator, all stage valids and sets leaky enable to 1.
// ----------------------------------------------------------------------------
module int8_conv_mac_bias_leaky (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [icmb_pkg::ACT_W-1:0]  activation,
	input  logic signed [icmb_pkg::WGT_W-1:0]  weight,
	input  logic signed [icmb_pkg::BIAS_W-1:0] bias,
	input  logic                                last_term,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [icmb_pkg::OUT_W-1:0]  out_value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data
);
	import icmb_pkg::*;

	localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(CLAMP_LIMIT);
	localparam logic signed [ACC_W-1:0] CLAMP_LO = -ACC_W'(CLAMP_LIMIT);

	logic                     advance;
	logic                     leaky_q;

	// stage 1: input register
	logic                     valid_s1;
	logic signed [ACT_W-1:0]  act_s1;
	logic signed [WGT_W-1:0]  wgt_s1;
	logic signed [BIAS_W-1:0] bias_s1;
	logic                     last_s1;

	// stage 2: product
	logic                     valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [BIAS_W-1:0] bias_s2;
	logic                     last_s2;

	// stage 3: clamped dot product
	logic                     valid_s3;
	logic signed [OUT_W-1:0]  clamp_s3;
	logic signed [BIAS_W-1:0] bias_s3;

	// stage 4: biased value
	logic                     valid_s4;
	logic signed [OUT_W-1:0]  biased_s4;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [OUT_W-1:0]  clamp_val;
	logic signed [OUT_W-1:0]  biased_val;
	logic signed [OUT_W-1:0]  leaky_val;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  out_value_q;

	// pipeline moves when the output register is free or being drained
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_value = out_value_q;

	// accumulate this product and clamp the running sum
	assign acc_sum = acc_q + ACC_W'(prod_s2);
	always_comb begin
		if (acc_sum > CLAMP_HI) begin
			clamp_val = OUT_W'(CLAMP_HI);
		end else if (acc_sum < CLAMP_LO) begin
			clamp_val = OUT_W'(CLAMP_LO);
		end else begin
			clamp_val = acc_sum[OUT_W-1:0];
		end
	end

	// bias add wraps to 16 bits
	assign biased_val = clamp_s3 + OUT_W'(bias_s3);

	icmb_leaky u_leaky (
		.leaky_enable (leaky_q),
		.value        (biased_s4),
		.result       (leaky_val)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaky_q <= LEAKY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			leaky_q <= cfg_data;
		end
	end

	// control: stage valids, accumulator, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2 && last_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
			if (valid_s2) begin
				acc_q <= last_s2 ? '0 : acc_sum;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (advance) begin
			act_s1      <= activation;
			wgt_s1      <= weight;
			bias_s1     <= bias;
			last_s1     <= last_term;
			prod_s2     <= act_s1 * wgt_s1;
			bias_s2     <= bias_s1;
			last_s2     <= last_s1;
			clamp_s3    <= clamp_val;
			bias_s3     <= bias_s2;
			biased_s4   <= biased_val;
			out_value_q <= leaky_val;
		end
	end

endmodule
